[design/fspc_pkg.sv]
// Shared types, constants and codes for the fan speed PID controller.
`default_nettype none
package fspc_pkg;

	localparam int unsigned RpmNumerator = 5000000;
	localparam int unsigned AlphaOne     = 65536;
	localparam int unsigned DutyMax      = 1000;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SETPOINT_RPM = 3'd0,
		REG_FILTER_ALPHA = 3'd1,
		REG_GAIN_P       = 3'd2,
		REG_GAIN_I       = 3'd3,
		REG_GAIN_D       = 3'd4,
		REG_STALL_RPM    = 3'd5,
		REG_STALL_TICKS  = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILT_MUL,
		ST_FILT_UPD,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_DUTY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;      // capture input period, start divider
		logic div_step;  // one quotient bit
		logic filt_mul;  // alpha times difference
		logic filt_upd;  // update filter value
		logic err;       // error, integral, derivative, stall counter
		logic mul_p;
		logic mul_i;
		logic mul_d;
		logic duty;      // clamp and load output register
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	typedef struct packed {
		logic [15:0] setpoint_rpm;
		logic [16:0] filter_alpha;
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [15:0] stall_rpm;
		logic [15:0] stall_ticks;
	} cfg_t;

endpackage
`default_nettype wire

[design/fspc_if.sv]
// Valid/ready channel interfaces for input, output and configuration.
`default_nettype none
interface fspc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] period_us;
	modport source (output valid, output period_us, input ready);
	modport sink (input valid, input period_us, output ready);
endinterface

interface fspc_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  duty;
	logic [13:0] compare_value;
	logic [22:0] speed_rpm;
	logic        stall_fault;
	modport source (output valid, output duty, output compare_value, output speed_rpm,
		output stall_fault, input ready);
	modport sink (input valid, input duty, input compare_value, input speed_rpm,
		input stall_fault, output ready);
endinterface

interface fspc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/fan_speed_pid_controller.sv]
// Top level of the fan speed PID controller.
// The in channel carries one tach period per control tick (0 = timeout).
// The out channel returns one result per tick: duty, compare value,
// filtered speed and the stall fault flag.
// The cfg channel writes registers by index 0..6 and is always ready;
// writes must be made only while the block is idle; the block does not enforce it.
// A tick runs the bit-serial 5000000/period divider (23 quotient bits and a
// done check), then filter multiply and update, error, three passes through
// the shared gain multiplier, a check of the output register and the clamp.
// The block works on one tick at a time, so a new period is taken only once
// the previous result has been loaded into the output register.
// While the receiver stalls, the result holds in the output register and the
// next tick completes up to the point of loading it.
// Reset restores the default registers, clears filter and PID state and
// loads the stall counter with 100.
`default_nettype none
module fan_speed_pid_controller (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fspc_in_if.sink     in_ch,
	fspc_out_if.source  out_ch,
	fspc_cfg_if.sink    cfg_ch
);
	import fspc_pkg::*;

	cmd_t    cmd;
	status_t status;
	cfg_t    cfg;
	logic    out_busy;

	fspc_cfg u_cfg (.clk, .arst_n, .cfg_ch, .cfg);

	fspc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_busy, .status, .cmd
	);

	fspc_dp u_dp (
		.clk, .arst_n, .cmd, .cfg,
		.period_us(in_ch.period_us),
		.status, .out_busy, .out_ch
	);
endmodule
`default_nettype wire

[design/fspc_ctrl.sv]
// Sequencer that steps the datapath through one control tick.
`default_nettype none
module fspc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              out_busy,
	input  wire fspc_pkg::status_t status,
	output fspc_pkg::cmd_t         cmd
);
	import fspc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_DIV;
			ST_DIV:      if (status.div_done) state_d = ST_FILT_MUL;
			ST_FILT_MUL: state_d = ST_FILT_UPD;
			ST_FILT_UPD: state_d = ST_ERR;
			ST_ERR:      state_d = ST_MUL_P;
			ST_MUL_P:    state_d = ST_MUL_I;
			ST_MUL_I:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_OUT;
			ST_OUT:      if (!out_busy) state_d = ST_DUTY;
			ST_DUTY:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV:      cmd.div_step = 1'b1;
			ST_FILT_MUL: cmd.filt_mul = 1'b1;
			ST_FILT_UPD: cmd.filt_upd = 1'b1;
			ST_ERR:      cmd.err = 1'b1;
			ST_MUL_P:    cmd.mul_p = 1'b1;
			ST_MUL_I:    cmd.mul_i = 1'b1;
			ST_MUL_D:    cmd.mul_d = 1'b1;
			ST_DUTY:     cmd.duty = 1'b1;
			default:     cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

[design/fspc_dp.sv]
// Datapath: divider, filter, stall counter, PID accumulator and output register.
`default_nettype none
module fspc_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fspc_pkg::cmd_t    cmd,
	input  wire fspc_pkg::cfg_t    cfg,
	input  wire logic [15:0]       period_us,
	output fspc_pkg::status_t      status,
	output logic                   out_busy,
	fspc_out_if.source             out_ch
);
	import fspc_pkg::*;

	// Restoring divider, one quotient bit per cycle.
	logic [22:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [4:0]  cnt_q;
	logic        zero_q;
	logic [16:0] trial;
	logic [22:0] num;

	assign num = 23'(RpmNumerator);
	assign trial = {rem_q, quo_q[22]} - {1'b0, div_q};
	assign status.div_done = (cnt_q == 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q  <= num;
			rem_q  <= '0;
			div_q  <= period_us;
			cnt_q  <= 5'd23;
			zero_q <= (period_us == 16'd0);
		end else if (cmd.div_step && cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[21:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[22]};
				quo_q <= {quo_q[21:0], 1'b0};
			end
		end
	end

	logic [22:0] raw;
	assign raw = zero_q ? 23'd0 : quo_q;

	// Filter state in Q16; 40 bits hold the largest raw speed.
	logic [39:0] filt_q;
	logic        primed_q;
	logic [40:0] diff;
	logic [39:0] fbase;
	logic        neg;
	logic [39:0] mag;
	logic [16:0] alpha;
	logic [56:0] prod_s1;
	logic        neg_s1;
	logic [40:0] step;

	assign fbase = primed_q ? filt_q : {1'b0, raw, 16'd0};
	assign diff  = {2'b0, raw, 16'd0} - {1'b0, fbase};
	assign neg   = diff[40];
	assign mag   = neg ? 40'(-diff) : diff[39:0];
	assign alpha = (cfg.filter_alpha > 17'(AlphaOne)) ? 17'(AlphaOne) : cfg.filter_alpha;
	assign step  = 41'((prod_s1 + 57'(neg_s1 ? 65535 : 0)) >> 16);

	logic [15:0] stall_q;
	logic        fault_q;
	logic [22:0] speed;
	assign speed = filt_q[38:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			filt_q   <= '0;
			stall_q  <= 16'd100;
		end else begin
			if (cmd.filt_mul && !primed_q) begin
				primed_q <= 1'b1;
				filt_q   <= fbase;
			end
			if (cmd.filt_upd) begin
				if (neg_s1) filt_q <= filt_q - step[39:0];
				else filt_q <= filt_q + step[39:0];
			end
			if (cmd.err) begin
				if (cfg.setpoint_rpm != 16'd0 && speed < 23'(cfg.stall_rpm)) begin
					if (stall_q != 16'd0) stall_q <= stall_q - 16'd1;
				end else begin
					stall_q <= cfg.stall_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.filt_mul) begin
			prod_s1 <= 57'(alpha) * 57'(mag);
			neg_s1  <= neg;
		end
		if (cmd.err)
			fault_q <= cfg.setpoint_rpm != 16'd0 && speed < 23'(cfg.stall_rpm)
				&& stall_q == 16'd1;
	end

	// PID terms; the error fits in 24 bits signed.
	logic signed [31:0] integ_q;
	logic signed [23:0] perr_q;
	logic signed [23:0] err_q;
	logic signed [24:0] deriv_q;
	logic signed [23:0] err_c;
	logic signed [32:0] isum;
	logic signed [31:0] isat;

	assign err_c = $signed({8'd0, cfg.setpoint_rpm}) - $signed({1'b0, speed});
	assign isum  = 33'(integ_q) + 33'(err_c);
	assign isat  = (isum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
		(isum < -33'sh080000000) ? 32'sh80000000 : isum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			perr_q  <= '0;
		end else if (cmd.err) begin
			integ_q <= isat;
			perr_q  <= err_c;
		end
	end

	// One shared 17x33 signed multiplier, accumulated over the P, I and D passes.
	logic signed [32:0] mop;
	logic signed [16:0] gop;
	logic signed [49:0] mprod;
	logic signed [51:0] acc_q;

	always_comb begin
		mop = 33'(err_q);
		gop = $signed({1'b0, cfg.gain_p});
		if (cmd.mul_i) begin
			mop = 33'(integ_q);
			gop = $signed({1'b0, cfg.gain_i});
		end else if (cmd.mul_d) begin
			mop = 33'(deriv_q);
			gop = $signed({1'b0, cfg.gain_d});
		end
	end
	assign mprod = 50'(mop) * 50'(gop);

	always_ff @(posedge clk) begin
		if (cmd.err) begin
			err_q   <= err_c;
			deriv_q <= 25'(err_c) - 25'(perr_q);
			acc_q   <= '0;
		end
		if (cmd.mul_p || cmd.mul_i || cmd.mul_d)
			acc_q <= acc_q + 52'(mprod);
	end

	logic [9:0]  duty_c;
	logic [39:0] q;
	assign q = 40'(acc_q >>> 12);
	always_comb begin
		if (acc_q < 0) duty_c = '0;
		else if (acc_q[51:12] > 40'(DutyMax)) duty_c = 10'(DutyMax);
		else duty_c = q[9:0];
	end

	// Output register; a finished result waits here for transfer.
	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.duty) ov_q <= 1'b1;
		else if (out_ch.ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.duty) begin
			out_ch.duty          <= duty_c;
			out_ch.compare_value <= {duty_c, 4'd0};
			out_ch.speed_rpm     <= speed;
			out_ch.stall_fault   <= fault_q;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_busy = ov_q && !out_ch.ready;
endmodule
`default_nettype wire

[design/fspc_cfg.sv]
// Configuration register file.
`default_nettype none
module fspc_cfg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fspc_cfg_if.sink        cfg_ch,
	output fspc_pkg::cfg_t  cfg
);
	import fspc_pkg::*;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.setpoint_rpm <= 16'd0;
			cfg.filter_alpha <= 17'd13166;
			cfg.gain_p       <= 16'd1638;
			cfg.gain_i       <= 16'd205;
			cfg.gain_d       <= 16'd0;
			cfg.stall_rpm    <= 16'd400;
			cfg.stall_ticks  <= 16'd100;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_SETPOINT_RPM: cfg.setpoint_rpm <= cfg_ch.data[15:0];
				REG_FILTER_ALPHA: cfg.filter_alpha <= cfg_ch.data;
				REG_GAIN_P:       cfg.gain_p       <= cfg_ch.data[15:0];
				REG_GAIN_I:       cfg.gain_i       <= cfg_ch.data[15:0];
				REG_GAIN_D:       cfg.gain_d       <= cfg_ch.data[15:0];
				REG_STALL_RPM:    cfg.stall_rpm    <= cfg_ch.data[15:0];
				REG_STALL_TICKS:  cfg.stall_ticks  <= cfg_ch.data[15:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

[bench/tb_fspc_scoreboard.sv]
// Scoreboard class for the fan speed PID controller testbench: tick predictor and result check.
class fspc_scoreboard;
	// Register copies.
	bit [15:0] setpoint_rpm;
	bit [16:0] filter_alpha;
	bit [15:0] gain_p;
	bit [15:0] gain_i;
	bit [15:0] gain_d;
	bit [15:0] stall_rpm;
	bit [15:0] stall_ticks;
	// Controller state.
	longint filter_value;
	bit primed;
	int integral_sum;
	int previous_error;
	bit [15:0] stall_count;
	// Expected results, oldest first.
	bit [47:0] pending_results[$];
	int errors;

	function void reset_state();
		setpoint_rpm = 0;
		filter_alpha = 13166;
		gain_p = 1638;
		gain_i = 205;
		gain_d = 0;
		stall_rpm = 400;
		stall_ticks = 100;
		filter_value = 0;
		primed = 0;
		integral_sum = 0;
		previous_error = 0;
		stall_count = 100;
		pending_results.delete();
		errors = 0;
	endfunction

	function void write_reg(fspc_pkg::reg_idx_t idx, bit [16:0] value);
		case (idx)
			fspc_pkg::REG_SETPOINT_RPM: setpoint_rpm = value[15:0];
			fspc_pkg::REG_FILTER_ALPHA: filter_alpha = value;
			fspc_pkg::REG_GAIN_P: gain_p = value[15:0];
			fspc_pkg::REG_GAIN_I: gain_i = value[15:0];
			fspc_pkg::REG_GAIN_D: gain_d = value[15:0];
			fspc_pkg::REG_STALL_RPM: stall_rpm = value[15:0];
			fspc_pkg::REG_STALL_TICKS: stall_ticks = value[15:0];
			default: ;
		endcase
	endfunction

	// Runs one control tick on an accepted period and queues the result.
	function void note_period(bit [15:0] period);
		longint raw_q, alpha, diff, speed, acc, sum;
		int error_now, deriv;
		bit [9:0] duty;
		bit fault;
		fault = 0;
		raw_q = (period != 0) ? longint'(5000000 / period) * 65536 : 0;
		alpha = (filter_alpha > 65536) ? 65536 : filter_alpha;
		if (!primed) begin
			filter_value = raw_q;
			primed = 1;
		end
		diff = raw_q - filter_value;
		// Rounds toward minus infinity in both directions.
		if (diff >= 0)
			filter_value += (alpha * diff) >>> 16;
		else
			filter_value -= (alpha * -diff + 65535) >>> 16;
		speed = filter_value >>> 16;
		if (setpoint_rpm != 0 && speed < stall_rpm) begin
			if (stall_count != 0) begin
				stall_count--;
				if (stall_count == 0)
					fault = 1;
			end
		end else begin
			stall_count = stall_ticks;
		end
		error_now = int'(longint'(setpoint_rpm) - speed);
		sum = longint'(integral_sum) + error_now;
		if (sum > 64'sd2147483647)
			integral_sum = 32'h7fffffff;
		else if (sum < -64'sd2147483648)
			integral_sum = 32'h80000000;
		else
			integral_sum = int'(sum);
		deriv = error_now - previous_error;
		previous_error = error_now;
		acc = longint'(gain_p) * error_now + longint'(gain_i) * integral_sum
			+ longint'(gain_d) * deriv;
		if (acc < 0)
			duty = 0;
		else if ((acc >>> 12) > 1000)
			duty = 1000;
		else
			duty = 10'(acc >>> 12);
		pending_results.push_back({duty, 14'(duty * 16), speed[22:0], fault});
	endfunction

	function int check_result(bit [9:0] duty, bit [13:0] cmp, bit [22:0] speed, bit fault);
		bit [47:0] want;
		if (pending_results.size() == 0) begin
			$display("ERROR: result with nothing expected (duty %0d)", duty);
			return 1;
		end
		want = pending_results.pop_front();
		if ({duty, cmp, speed, fault} != want) begin
			$display("ERROR: got duty %0d cmp %0d speed %0d fault %0d, want %0d %0d %0d %0d",
				duty, cmp, speed, fault, want[47:38], want[37:24], want[23:1], want[0]);
			return 1;
		end
		return 0;
	endfunction
endclass

[bench/tb_fan_speed_pid_controller.sv]
// Top-level testbench for the fan speed PID controller.
module tb_fan_speed_pid_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import fspc_pkg::*;

	logic clk;
	logic arst_n;
	fspc_in_if in_ch();
	fspc_out_if out_ch();
	fspc_cfg_if cfg_ch();

	fan_speed_pid_controller dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	fspc_scoreboard tick_model;
	int mismatch_count;
	longint cycle_count;
	bit hold_off;     // long receiver stall requested

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH: %s", what);
		mismatch_count++;
	endtask

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	task automatic write_register(reg_idx_t idx, bit [16:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		tick_model.write_reg(idx, value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Offers one period and returns at the edge of its transfer; valid stays
	// high until the next period or the drain takes over.
	task automatic send_period(bit [15:0] period, bit use_gaps);
		int gap;
		gap = use_gaps ? gap_length() : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.period_us <= period;
		do @(posedge clk); while (!in_ch.ready);
		tick_model.note_period(period);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tick_model.pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic bit [15:0] random_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 16'd0;
		if (r < 15)
			return 16'($urandom_range(1, 20));
		if (r < 60)
			return 16'($urandom_range(300, 3000));
		return 16'($urandom);
	endfunction

	task automatic random_config(bit extreme);
		write_register(REG_SETPOINT_RPM, extreme ? ($urandom_range(0, 1) ? 17'h0ffff : 17'd0)
			: 17'($urandom_range(0, 12000)));
		write_register(REG_FILTER_ALPHA, extreme ? ($urandom_range(0, 1) ? 17'h1ffff : 17'd0)
			: 17'($urandom_range(0, 70000)));
		write_register(REG_GAIN_P, extreme ? 17'h0ffff : 17'($urandom_range(0, 8000)));
		write_register(REG_GAIN_I, extreme ? 17'h0ffff : 17'($urandom_range(0, 2000)));
		write_register(REG_GAIN_D, extreme ? 17'h0ffff : 17'($urandom_range(0, 3000)));
		write_register(REG_STALL_RPM, extreme ? 17'h0ffff : 17'($urandom_range(0, 3000)));
		write_register(REG_STALL_TICKS, extreme ? 17'($urandom_range(0, 1))
			: 17'($urandom_range(0, 30)));
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			gap = gap_length();
			if (gap != 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (tick_model.check_result(out_ch.duty, out_ch.compare_value, out_ch.speed_rpm,
				out_ch.stall_fault))
				report_mismatch("result differs from prediction");
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		bit [15:0] directed[$] = '{16'd1000, 16'd0, 16'd1, 16'hffff, 16'd2, 16'd76,
			16'd77, 16'd12500, 16'd5000, 16'd0, 16'd0, 16'h8000, 16'h5555, 16'h2aaa};
		tick_model = new();
		tick_model.reset_state();
		mismatch_count = 0;
		cycle_count = 0;
		hold_off = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.period_us = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SETPOINT_RPM;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Defaults first, then a commanded fan that never spins to hit stall faults.
		foreach (directed[i])
			send_period(directed[i], 0);
		drain();
		write_register(REG_SETPOINT_RPM, 17'h0ffff);
		write_register(REG_STALL_TICKS, 17'd3);
		write_register(REG_GAIN_I, 17'h0ffff);
		write_register(REG_FILTER_ALPHA, 17'h1ffff);
		for (int i = 0; i < 8; i++)
			send_period(16'd0, 1);
		drain();

		for (int phase = 0; phase < 20; phase++) begin
			random_config(phase % 5 == 0);
			if (phase == 3)
				hold_off = 1;
			for (int i = 0; i < 100; i++)
				send_period(random_period(), phase != 3);
			// Sender pauses until every expected result has come.
			drain();
		end

		if (tick_model.pending_results.size() != 0)
			mismatch_count++;
		mismatch_count += tick_model.errors;
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
